/* hdl/mbtcp_pkg.sv */
// ----------------------------------------------------------------------------
// Modbus TCP read-holding-registers responder package
// Shared constants and the command/status types between controller and
// datapath.
// ----------------------------------------------------------------------------
package mbtcp_pkg;

    // Number of request bytes that are kept (MBAP header plus PDU).
    localparam int REQ_LEN = 12;
    localparam int CNT_W   = 4;

    // Holding registers that are fed by sensor updates.
    localparam int SENSOR_REGS  = 6;
    localparam int SENSOR_IDX_W = 3;

    localparam int DEFAULT_REG_COUNT = 6;

    localparam logic [7:0] FC_READ_HOLDING     = 8'h03;
    localparam logic [7:0] FC_ERROR_FLAG       = 8'h80;
    localparam logic [7:0] EXC_ILLEGAL_ADDRESS = 8'h02;
    localparam logic [7:0] EXC_LENGTH          = 8'h03;

    // Request byte positions.
    localparam int REQ_TID_HI = 0;
    localparam int REQ_TID_LO = 1;
    localparam int REQ_UNIT   = 6;
    localparam int REQ_FC     = 7;
    localparam int REQ_ADR_HI = 8;
    localparam int REQ_ADR_LO = 9;
    localparam int REQ_QTY_HI = 10;
    localparam int REQ_QTY_LO = 11;

    // Response byte positions of the fixed part of the frame.
    localparam int RSP_TID_HI = 0;
    localparam int RSP_TID_LO = 1;
    localparam int RSP_PID_HI = 2;
    localparam int RSP_PID_LO = 3;
    localparam int RSP_LEN_HI = 4;
    localparam int RSP_LEN_LO = 5;
    localparam int RSP_UNIT   = 6;
    localparam int RSP_FC     = 7;
    localparam int RSP_BCNT   = 8;
    localparam int RSP_HDR_LEN = 9;

    typedef struct packed {
        logic accept;  // an input transaction completes this cycle
        logic load;    // set up the reply for the stored request
        logic emit;    // put the next reply byte into the output register
    } t_cmd;

    typedef struct packed {
        logic req_full;   // the last segment carried at least twelve bytes
        logic fc_ok;      // stored function code is read holding registers
        logic out_free;   // output register can take a byte
        logic last_byte;  // the byte about to be emitted ends the frame
    } t_stat;

endpackage

/* hdl/mbtcp_ctrl.sv */
// ----------------------------------------------------------------------------
// Modbus TCP responder controller
// Sequences input acceptance, the request check and the reply burst.
// ----------------------------------------------------------------------------
module mbtcp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    input  logic             i_s_axis_tlast,
    input  logic             i_s_axis_tuser,
    output logic             o_s_axis_tready,
    input  mbtcp_pkg::t_stat i_stat,
    output mbtcp_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_SEND  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.emit   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_s_axis_tvalid;
                // A request byte that closes a segment triggers the check.
                if (i_s_axis_tvalid && !i_s_axis_tuser && i_s_axis_tlast) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.req_full && i_stat.fc_ok) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SEND;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SEND: begin
                o_cmd.emit = i_stat.out_free;
                if (i_stat.out_free && i_stat.last_byte) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTH
    a_check_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHECK |=> r_state != S_CHECK)
        else $error("check state held for more than one cycle");

    a_seg_end_checks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && !i_s_axis_tuser && i_s_axis_tlast
        |=> r_state == S_CHECK)
        else $error("segment end did not start a request check");

    a_emit_in_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> r_state == S_SEND)
        else $error("reply byte emitted outside the send state");
`endif

endmodule

/* hdl/mbtcp_dp.sv */
// ----------------------------------------------------------------------------
// Modbus TCP responder datapath
// Request byte store, holding register bank, reply byte generator and the
// output register.
// ----------------------------------------------------------------------------
module mbtcp_dp #(
    parameter int REG_COUNT = mbtcp_pkg::DEFAULT_REG_COUNT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [103:0]     i_s_axis_tdata,
    input  logic             i_s_axis_tlast,
    input  logic             i_s_axis_tuser,
    input  logic             i_m_axis_tready,
    output logic             o_m_axis_tvalid,
    output logic [7:0]       o_m_axis_tdata,
    output logic             o_m_axis_tlast,
    input  mbtcp_pkg::t_cmd  i_cmd,
    output mbtcp_pkg::t_stat o_stat
);

    localparam int PW = (REG_COUNT > 8) ? $clog2(REG_COUNT) : 3;
    localparam int IW = $clog2(mbtcp_pkg::RSP_HDR_LEN + 2 * REG_COUNT);

    logic [7:0]                   r_req [mbtcp_pkg::REQ_LEN];
    logic [mbtcp_pkg::CNT_W-1:0]  r_cnt;
    logic                         r_full;
    logic [15:0]                  r_hold [mbtcp_pkg::SENSOR_REGS];

    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_last_idx;
    logic [PW-1:0] r_ptr;
    logic          r_exc;
    logic [7:0]    r_bcnt;

    logic          r_out_valid;
    logic [7:0]    r_out_data;
    logic          r_out_last;

    logic [15:0] w_start;
    logic [15:0] w_qty;
    logic [16:0] w_end;
    logic        w_bad;
    logic [15:0] w_reg;
    logic [7:0]  w_byte;

    assign w_start = {r_req[mbtcp_pkg::REQ_ADR_HI], r_req[mbtcp_pkg::REQ_ADR_LO]};
    assign w_qty   = {r_req[mbtcp_pkg::REQ_QTY_HI], r_req[mbtcp_pkg::REQ_QTY_LO]};
    assign w_end   = {1'b0, w_start} + {1'b0, w_qty};
    assign w_bad   = (w_qty == 16'd0) || ({1'b0, w_qty} > 17'(REG_COUNT))
                     || (w_end > 17'(REG_COUNT));

    // Registers above the sensor bank always read as zero.
    assign w_reg = (r_ptr < PW'(mbtcp_pkg::SENSOR_REGS))
                   ? r_hold[r_ptr[mbtcp_pkg::SENSOR_IDX_W-1:0]] : 16'd0;

    always_comb begin
        case (r_idx)
            IW'(mbtcp_pkg::RSP_TID_HI): w_byte = r_req[mbtcp_pkg::REQ_TID_HI];
            IW'(mbtcp_pkg::RSP_TID_LO): w_byte = r_req[mbtcp_pkg::REQ_TID_LO];
            IW'(mbtcp_pkg::RSP_PID_HI): w_byte = 8'd0;
            IW'(mbtcp_pkg::RSP_PID_LO): w_byte = 8'd0;
            IW'(mbtcp_pkg::RSP_LEN_HI): w_byte = 8'd0;
            IW'(mbtcp_pkg::RSP_LEN_LO): begin
                w_byte = r_exc ? mbtcp_pkg::EXC_LENGTH
                               : mbtcp_pkg::EXC_LENGTH + r_bcnt;
            end
            IW'(mbtcp_pkg::RSP_UNIT): w_byte = r_req[mbtcp_pkg::REQ_UNIT];
            IW'(mbtcp_pkg::RSP_FC): begin
                w_byte = r_exc ? (mbtcp_pkg::FC_READ_HOLDING | mbtcp_pkg::FC_ERROR_FLAG)
                               : mbtcp_pkg::FC_READ_HOLDING;
            end
            IW'(mbtcp_pkg::RSP_BCNT): begin
                w_byte = r_exc ? mbtcp_pkg::EXC_ILLEGAL_ADDRESS : r_bcnt;
            end
            default: begin
                // Register data: odd positions carry the high byte.
                w_byte = r_idx[0] ? w_reg[15:8] : w_reg[7:0];
            end
        endcase
    end

    assign o_stat.req_full  = r_full;
    assign o_stat.fc_ok     = (r_req[mbtcp_pkg::REQ_FC] == mbtcp_pkg::FC_READ_HOLDING);
    assign o_stat.out_free  = !r_out_valid || i_m_axis_tready;
    assign o_stat.last_byte = (r_idx == r_last_idx);

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    // Request byte store; no reset, only read after twelve writes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !i_s_axis_tuser &&
            r_cnt < mbtcp_pkg::CNT_W'(mbtcp_pkg::REQ_LEN)) begin
            r_req[r_cnt] <= i_s_axis_tdata[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_full <= 1'b0;
        end else if (i_cmd.accept && !i_s_axis_tuser) begin
            if (i_s_axis_tlast) begin
                r_cnt  <= '0;
                r_full <= (r_cnt >= mbtcp_pkg::CNT_W'(mbtcp_pkg::REQ_LEN - 1));
            end else if (r_cnt < mbtcp_pkg::CNT_W'(mbtcp_pkg::REQ_LEN)) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mbtcp_pkg::SENSOR_REGS; i++) begin
                r_hold[i] <= 16'd0;
            end
        end else if (i_cmd.accept && i_s_axis_tuser) begin
            for (int i = 0; i < mbtcp_pkg::SENSOR_REGS; i++) begin
                r_hold[i] <= i_s_axis_tdata[8 + 16 * i +: 16];
            end
        end
    end

    // Reply sequencing: byte index and register pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.emit) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_exc      <= w_bad;
            r_ptr      <= w_start[PW-1:0];
            r_bcnt     <= {w_qty[6:0], 1'b0};
            r_last_idx <= w_bad ? IW'(mbtcp_pkg::RSP_BCNT)
                                : IW'(mbtcp_pkg::RSP_BCNT) + IW'({w_qty[7:0], 1'b0});
        end else if (i_cmd.emit && r_idx >= IW'(mbtcp_pkg::RSP_HDR_LEN) && !r_idx[0]) begin
            r_ptr <= r_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= w_byte;
            r_out_last <= (r_idx == r_last_idx);
        end
    end

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= mbtcp_pkg::CNT_W'(mbtcp_pkg::REQ_LEN))
        else $error("request byte count beyond twelve");

    a_load_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> r_idx == '0)
        else $error("reply did not restart at byte zero");
`endif

endmodule

/* hdl/modbus_tcp_read_holding_responder_unit.sv */
// ----------------------------------------------------------------------------
// Modbus TCP read holding registers responder
// Answers function 0x03 requests from a byte stream with register data.
// ----------------------------------------------------------------------------
// Input channel (s_axis): one transaction per cycle while tready is high.
// tuser 0 carries a received request byte in tdata[7:0], tlast marking the
// end of a network segment. tuser 1 carries a sensor bank update in
// tdata[103:8], six 16-bit holding register values.
// At a segment end the block checks the first twelve stored bytes in the
// check state. A short segment or a foreign function code gives no reply;
// a bad address or quantity gives the 9-byte exception frame; otherwise the
// header and 2*quantity big-endian data bytes follow.
// Output channel (m_axis): one reply byte per transaction in tdata[7:0],
// tlast on the final byte. The first reply byte is registered in the send
// state, which comes after the check state, and bytes follow one per cycle
// while the output takes them. tready on the input is low from the segment
// end until the last reply byte sits in the output register; an output
// stall holds the reply byte and stops the burst.
// Reset clears the byte count, the holding registers and the output valid.
// ----------------------------------------------------------------------------
module modbus_tcp_read_holding_responder_unit #(
    parameter int REG_COUNT = mbtcp_pkg::DEFAULT_REG_COUNT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // rx_byte[7:0], temperature[23:8], humidity[39:24], air_quality[55:40],
    // vibration[71:56], risk_level[87:72], smoke_flag[103:88]
    input  logic [103:0] i_s_axis_tdata,
    input  logic         i_s_axis_tlast,  // segment_end
    input  logic         i_s_axis_tuser,  // mode
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [7:0]   o_m_axis_tdata,  // tx_byte[7:0]
    output logic         o_m_axis_tlast   // last
);

    mbtcp_pkg::t_cmd  w_cmd;
    mbtcp_pkg::t_stat w_stat;

    mbtcp_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (w_stat),
        .o_cmd           (w_cmd)
    );

    mbtcp_dp #(
        .REG_COUNT (REG_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat)
    );

endmodule

/* tb/sv/tb_modbus_tcp_read_holding_responder_unit.sv */
// ----------------------------------------------------------------------------
// Testbench for the Modbus TCP read holding registers responder
// Sends request bytes and sensor bank updates over the input stream and
// checks every reply byte against a predictor of the responder. A directed
// table covers the edge cases of the request. Random traffic follows, mostly
// well-formed requests with some noise, under changing stalls on both sides.
// ----------------------------------------------------------------------------
module tb_modbus_tcp_read_holding_responder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mbtcp_pkg::*;

    localparam int REG_COUNT    = DEFAULT_REG_COUNT;
    localparam int RANDOM_ITEMS = 330;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_SHOWN    = 10;

    typedef struct packed {
        logic             mode;     // 1: sensor bank update
        logic             seg_end;
        logic [5:0][15:0] bank;     // bank[0] is temperature
        logic [7:0]       rx;
    } t_bus_item;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_reply_byte;

    typedef enum logic {ROW_UPDATE, ROW_SEGMENT} t_row_kind;
    typedef enum logic [1:0] {OUT_MODEL, OUT_NONE, OUT_EXCEPTION, OUT_ZERO_REGS} t_outcome;

    typedef struct packed {
        t_row_kind        kind;
        logic [15:0]      tid;
        logic [31:0]      mbap;     // protocol id and length as sent
        logic [7:0]       unit;
        logic [7:0]       fc;
        logic [15:0]      start_adr;
        logic [15:0]      qty;
        logic [4:0]       nbytes;
        logic [5:0][15:0] bank;
        t_outcome         outcome;
    } t_stim_row;

    localparam t_stim_row DIR_TAB [17] = '{
        // Registers read right after reset are all zero.
        '{ROW_SEGMENT, 16'h0000, 32'h0000_0006, 8'h00, FC_READ_HOLDING, 16'd0, 16'd6,
          5'd12, '0, OUT_ZERO_REGS},
        '{ROW_UPDATE, 16'h0, 32'h0, 8'h0, 8'h0, 16'd0, 16'd0, 5'd0, {6{16'hFFFF}}, OUT_NONE},
        '{ROW_SEGMENT, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, FC_READ_HOLDING, 16'd0, 16'd6,
          5'd12, '0, OUT_MODEL},
        '{ROW_UPDATE, 16'h0, 32'h0, 8'h0, 8'h0, 16'd0, 16'd0, 5'd0,
          {16'hA5A5, 16'h8001, 16'h7FFE, 16'h0102, 16'hFEDC, 16'h1234}, OUT_NONE},
        '{ROW_SEGMENT, 16'h1357, 32'h0000_0006, 8'h11, FC_READ_HOLDING, 16'd5, 16'd1,
          5'd12, '0, OUT_MODEL},
        '{ROW_SEGMENT, 16'h2468, 32'h0000_0006, 8'h22, FC_READ_HOLDING, 16'd0, 16'd0,
          5'd12, '0, OUT_EXCEPTION},
        '{ROW_SEGMENT, 16'h0102, 32'h0000_0006, 8'h33, FC_READ_HOLDING, 16'd0, 16'd7,
          5'd12, '0, OUT_EXCEPTION},
        '{ROW_SEGMENT, 16'h8000, 32'h0000_0006, 8'h44, FC_READ_HOLDING, 16'd1, 16'd6,
          5'd12, '0, OUT_EXCEPTION},
        '{ROW_SEGMENT, 16'h7FFF, 32'h0000_0006, 8'h55, FC_READ_HOLDING, 16'hFFFF, 16'hFFFF,
          5'd12, '0, OUT_EXCEPTION},
        '{ROW_SEGMENT, 16'h0A0B, 32'h0000_0006, 8'h66, 8'h04, 16'd0, 16'd2,
          5'd12, '0, OUT_NONE},
        '{ROW_SEGMENT, 16'h0C0D, 32'h0000_0006, 8'h77, FC_READ_HOLDING | FC_ERROR_FLAG,
          16'd0, 16'd2, 5'd12, '0, OUT_NONE},
        '{ROW_SEGMENT, 16'h0E0F, 32'h0000_0006, 8'h88, 8'h00, 16'd0, 16'd2,
          5'd12, '0, OUT_NONE},
        '{ROW_SEGMENT, 16'h1111, 32'h0000_0006, 8'h99, FC_READ_HOLDING, 16'd0, 16'd2,
          5'd11, '0, OUT_NONE},
        '{ROW_SEGMENT, 16'h2222, 32'h0000_0006, 8'hAA, FC_READ_HOLDING, 16'd0, 16'd2,
          5'd1, '0, OUT_NONE},
        '{ROW_SEGMENT, 16'h3333, 32'h0000_0006, 8'hBB, FC_READ_HOLDING, 16'd2, 16'd3,
          5'd20, '0, OUT_MODEL},
        '{ROW_UPDATE, 16'h0, 32'h0, 8'h0, 8'h0, 16'd0, 16'd0, 5'd0,
          {16'h0001, 16'h8000, 16'h00FF, 16'hFF00, 16'h5A5A, 16'h0000}, OUT_NONE},
        '{ROW_SEGMENT, 16'h4444, 32'h0000_0006, 8'hCC, FC_READ_HOLDING, 16'd0, 16'd6,
          5'd12, '0, OUT_MODEL}
    };

    logic         i_clk;
    logic         i_rst_n         = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    // rx_byte[7:0], temperature[23:8], humidity[39:24], air_quality[55:40],
    // vibration[71:56], risk_level[87:72], smoke_flag[103:88]
    logic [103:0] i_s_axis_tdata  = '0;
    logic         i_s_axis_tlast  = 1'b0;  // segment_end
    logic         i_s_axis_tuser  = 1'b0;  // mode
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [7:0]   o_m_axis_tdata;          // tx_byte[7:0]
    logic         o_m_axis_tlast;          // last

    modbus_tcp_read_holding_responder_unit DUT (.*);

    // Predictor state.
    logic [7:0]  req_mem [REQ_LEN];
    int          req_cnt = 0;
    logic [15:0] bank_regs [REG_COUNT];
    t_reply_byte reply_q [$];

    t_outcome    typed_outcome = OUT_MODEL;
    logic [15:0] typed_tid;
    logic [7:0]  typed_unit;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_serial = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int idle_run    = 0;

    int n_items    = 0;
    int n_updates  = 0;
    int n_segments = 0;
    int n_checked  = 0;
    int n_frames   = 0;
    int err_count  = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [11:0][7:0] pack_req(input logic [15:0] tid, input logic [31:0] mbap,
                                                  input logic [7:0] unit, input logic [7:0] fc,
                                                  input logic [15:0] start_adr,
                                                  input logic [15:0] qty);
        // Byte 0 of the request sits in the lowest bits.
        return {qty[7:0], qty[15:8], start_adr[7:0], start_adr[15:8], fc, unit,
                mbap[7:0], mbap[15:8], mbap[23:16], mbap[31:24], tid[7:0], tid[15:8]};
    endfunction

    // Updates the predictor with one accepted input and returns the reply it causes.
    function automatic void compute_reply(input t_bus_item it, output t_reply_byte fr[$]);
        int         first;
        int         qty;
        logic [7:0] b [$];
        fr.delete();
        if (it.mode) begin
            for (int i = 0; i < SENSOR_REGS; i++) bank_regs[i] = it.bank[i];
            return;
        end
        if (req_cnt < REQ_LEN) begin
            req_mem[req_cnt] = it.rx;
            req_cnt++;
        end
        if (it.seg_end) begin
            if (req_cnt == REQ_LEN && req_mem[REQ_FC] == FC_READ_HOLDING) begin
                first = {req_mem[REQ_ADR_HI], req_mem[REQ_ADR_LO]};
                qty   = {req_mem[REQ_QTY_HI], req_mem[REQ_QTY_LO]};
                b.push_back(req_mem[REQ_TID_HI]);
                b.push_back(req_mem[REQ_TID_LO]);
                b.push_back(8'h00);
                b.push_back(8'h00);
                b.push_back(8'h00);
                if (qty == 0 || qty > REG_COUNT || first + qty > REG_COUNT) begin
                    b.push_back(8'd3);
                    b.push_back(req_mem[REQ_UNIT]);
                    b.push_back(FC_READ_HOLDING | FC_ERROR_FLAG);
                    b.push_back(EXC_ILLEGAL_ADDRESS);
                end else begin
                    b.push_back(8'(3 + 2 * qty));
                    b.push_back(req_mem[REQ_UNIT]);
                    b.push_back(FC_READ_HOLDING);
                    b.push_back(8'(2 * qty));
                    for (int i = 0; i < qty; i++) begin
                        b.push_back(bank_regs[first + i][15:8]);
                        b.push_back(bank_regs[first + i][7:0]);
                    end
                end
                foreach (b[i]) fr.push_back(t_reply_byte'{b[i], i == b.size() - 1});
            end
            req_cnt = 0;
        end
    endfunction

    task automatic send_item(input t_bus_item it);
        t_reply_byte fr [$];
        logic [71:0] hdr;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {it.bank, it.rx};
        i_s_axis_tlast  <= it.seg_end;
        i_s_axis_tuser  <= it.mode;
        do @(posedge i_clk); while (!o_s_axis_tready);
        n_items++;
        if (it.mode) n_updates++;
        else if (it.seg_end) n_segments++;
        compute_reply(it, fr);
        // Directed rows may carry a reply written out by hand instead.
        if (!it.mode && it.seg_end && typed_outcome != OUT_MODEL) begin
            fr.delete();
            if (typed_outcome == OUT_EXCEPTION) begin
                hdr = {typed_tid, 24'h000000, 8'd3, typed_unit,
                       FC_READ_HOLDING | FC_ERROR_FLAG, EXC_ILLEGAL_ADDRESS};
            end else begin
                // All six registers: length 15, byte count 12.
                hdr = {typed_tid, 24'h000000, 8'd15, typed_unit, FC_READ_HOLDING, 8'd12};
            end
            if (typed_outcome != OUT_NONE) begin
                for (int i = 0; i < 9; i++) begin
                    fr.push_back(t_reply_byte'{hdr[71 - 8 * i -: 8], 1'b0});
                end
                if (typed_outcome == OUT_ZERO_REGS) begin
                    repeat (2 * SENSOR_REGS) fr.push_back(t_reply_byte'{8'h00, 1'b0});
                end
                fr[fr.size() - 1].last = 1'b1;
            end
        end
        foreach (fr[i]) reply_q.push_back(fr[i]);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_update(input logic [5:0][15:0] bank);
        t_bus_item it;
        it.mode    = 1'b1;
        it.seg_end = 1'($urandom_range(1));
        it.bank    = bank;
        it.rx      = 8'($urandom);
        send_item(it);
    endtask

    // Sends one segment; a bank update goes in before byte upd_at if it is not negative.
    task automatic send_request(input logic [11:0][7:0] req, input int nbytes, input int upd_at);
        t_bus_item it;
        for (int i = 0; i < nbytes; i++) begin
            if (i == upd_at) send_update({$urandom, $urandom, $urandom});
            it.mode    = 1'b0;
            it.seg_end = (i == nbytes - 1);
            it.bank    = {$urandom, $urandom, $urandom};
            it.rx      = (i < REQ_LEN) ? req[i] : 8'($urandom);
            send_item(it);
        end
    endtask

    task automatic random_request();
        logic [15:0] first;
        logic [15:0] qty;
        logic [7:0]  fc;
        int          r;
        int          nb;
        int          upd_at;
        fc = ($urandom_range(9) == 0) ? 8'($urandom) : FC_READ_HOLDING;
        r  = $urandom_range(99);
        if (r < 60) begin
            first = 16'($urandom_range(0, REG_COUNT - 1));
            qty   = 16'($urandom_range(1, REG_COUNT - first));
        end else if (r < 85) begin
            first = 16'($urandom_range(0, REG_COUNT));
            qty   = 16'($urandom_range(0, REG_COUNT + 1));
        end else begin
            first = 16'($urandom);
            qty   = 16'($urandom);
        end
        r  = $urandom_range(99);
        nb = (r < 85) ? REQ_LEN : (r < 93) ? $urandom_range(REQ_LEN + 1, 20)
                                            : $urandom_range(1, REQ_LEN - 1);
        upd_at = ($urandom_range(19) == 0) ? $urandom_range(0, nb - 1) : -1;
        send_request(pack_req(16'($urandom), $urandom, 8'($urandom), fc, first, qty),
                     nb, upd_at);
    endtask

    // Stops offering and waits until every predicted reply byte has come out.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (reply_q.size() != 0);
    endtask

    // Output side: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        if (hold_serial != hold_seen) begin
            hold_seen       <= hold_serial;
            hold_left       <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_replies
        t_reply_byte want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            n_checked++;
            if (o_m_axis_tlast) n_frames++;
            if (reply_q.size() == 0) begin
                err_count++;
                if (err_count <= MAX_SHOWN) begin
                    $display("Unexpected reply byte %02h last %0b with nothing pending",
                             o_m_axis_tdata, o_m_axis_tlast);
                end
            end else begin
                want = reply_q.pop_front();
                if (o_m_axis_tdata !== want.data || o_m_axis_tlast !== want.last) begin
                    err_count++;
                    if (err_count <= MAX_SHOWN) begin
                        $display("Reply byte %0d: expected data %02h last %0b, got %02h last %0b",
                                 n_checked, want.data, want.last, o_m_axis_tdata,
                                 o_m_axis_tlast);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_run <= 0;
        end else if (idle_run >= STALL_LIMIT) begin
            $display("No transaction for %0d cycles, %0d reply bytes outstanding",
                     STALL_LIMIT, reply_q.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    initial begin
        int dir_items;
        int r;
        for (int i = 0; i < REG_COUNT; i++) bank_regs[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 6;
        rx_idle_pct = 86;
        foreach (DIR_TAB[k]) begin
            typed_outcome = DIR_TAB[k].outcome;
            typed_tid     = DIR_TAB[k].tid;
            typed_unit    = DIR_TAB[k].unit;
            if (DIR_TAB[k].kind == ROW_UPDATE) begin
                send_update(DIR_TAB[k].bank);
            end else begin
                send_request(pack_req(DIR_TAB[k].tid, DIR_TAB[k].mbap, DIR_TAB[k].unit,
                                      DIR_TAB[k].fc, DIR_TAB[k].start_adr, DIR_TAB[k].qty),
                             DIR_TAB[k].nbytes, -1);
            end
        end
        typed_outcome = OUT_MODEL;
        dir_items     = n_items;

        for (int ph = 0; ph < 3; ph++) begin
            wait_drained();
            tx_idle_pct = (ph == 1) ? 86 : (ph == 0) ? 6 : 0;
            rx_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 6 : 0;
            // The output stalls for a long stretch while requests keep coming.
            hold_serial <= hold_serial + 1;
            while (n_items < dir_items + (ph + 1) * RANDOM_ITEMS / 3) begin
                r = $urandom_range(99);
                if (r < 72) begin
                    random_request();
                end else if (r < 86) begin
                    send_update({$urandom, $urandom, $urandom});
                end else begin
                    // Stray bytes that break up the request framing.
                    repeat ($urandom_range(1, 4)) begin
                        send_item(t_bus_item'{1'b0, 1'($urandom_range(1)),
                                              {$urandom, $urandom, $urandom}, 8'($urandom)});
                    end
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        err_count += reply_q.size();

        $display("Covered %0d input transactions: %0d bank updates, %0d segment ends",
                 n_items, n_updates, n_segments);
        $display("Checked %0d reply frames, %0d bytes, %0d mismatches",
                 n_frames, n_checked, err_count);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
